// File: rtl/core/sdaq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdaq_pkg
// Shared types, constants and tap tables of the dithering quantizer.
// ----------------------------------------------------------------------------
package sdaq_pkg;

	localparam int NUM_CH    = 4;
	localparam int PIX_W     = 8;
	localparam int ERR_W     = 9;
	localparam int ACC_W     = 14;
	localparam int V_W       = 12;
	localparam int VMAG_W    = 10;
	localparam int NUM_TAPS  = 10;
	localparam int TAP_W     = 4;
	localparam int DIV_CNT_W = 4;

	localparam logic [7:0]  QSTEP_RESET = 8'd16;
	localparam logic [11:0] WIDTH_RESET = 12'd2048;

	// Register indexes on the configuration port.
	localparam logic REG_QUANT_STEP  = 1'b0;
	localparam logic REG_IMAGE_WIDTH = 1'b1;

	// Error row selectors of a tap.
	localparam logic [1:0] ROW_CUR = 2'd0;
	localparam logic [1:0] ROW_UP1 = 2'd1;
	localparam logic [1:0] ROW_UP2 = 2'd2;

	typedef struct packed {
		logic [7:0]  quant_step;
		logic [11:0] image_width;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAP,
		ST_DRAIN,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] k);
		case (k)
			4'd0, 4'd1, 4'd2: tap_row = ROW_UP2;
			4'd3, 4'd4, 4'd5, 4'd6, 4'd7: tap_row = ROW_UP1;
			default: tap_row = ROW_CUR;
		endcase
	endfunction

	function automatic logic signed [2:0] tap_dx(input logic [TAP_W-1:0] k);
		case (k)
			4'd0: tap_dx = -3'sd1;
			4'd1: tap_dx = 3'sd0;
			4'd2: tap_dx = 3'sd1;
			4'd3: tap_dx = -3'sd2;
			4'd4: tap_dx = -3'sd1;
			4'd5: tap_dx = 3'sd0;
			4'd6: tap_dx = 3'sd1;
			4'd7: tap_dx = 3'sd2;
			4'd8: tap_dx = -3'sd2;
			default: tap_dx = -3'sd1;
		endcase
	endfunction

	function automatic logic [2:0] tap_wt(input logic [TAP_W-1:0] k);
		case (k)
			4'd0: tap_wt = 3'd2;
			4'd1: tap_wt = 3'd3;
			4'd2: tap_wt = 3'd2;
			4'd3: tap_wt = 3'd2;
			4'd4: tap_wt = 3'd4;
			4'd5: tap_wt = 3'd5;
			4'd6: tap_wt = 3'd4;
			4'd7: tap_wt = 3'd2;
			4'd8: tap_wt = 3'd3;
			default: tap_wt = 3'd5;
		endcase
	endfunction

	// Row slot arithmetic modulo three.
	function automatic logic [1:0] phase_add(input logic [1:0] p, input logic [1:0] n);
		logic [2:0] s;
		s = {1'b0, p} + {1'b0, n};
		phase_add = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/sdaq_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdaq_cfg
// APB register bank holding the quantization step and the image width.
// ----------------------------------------------------------------------------
module sdaq_cfg
	import sdaq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quant_step  <= QSTEP_RESET;
			cfg_q.image_width <= WIDTH_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_QUANT_STEP:  cfg_q.quant_step  <= pwdata[7:0];
				REG_IMAGE_WIDTH: cfg_q.image_width <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_QUANT_STEP:  prdata = {24'd0, cfg_q.quant_step};
			REG_IMAGE_WIDTH: prdata = {20'd0, cfg_q.image_width};
			default:         prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/sdaq_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdaq_div
// Restoring divider, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module sdaq_div
	import sdaq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [VMAG_W-1:0] dividend,
	input  wire logic [7:0]        divisor,
	output logic      [7:0]        rem,
	output logic                   done
);

	logic [7:0]           rem_q;
	logic [7:0]           dsr_q;
	logic [VMAG_W-1:0]    dvd_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [8:0]           trial;

	assign trial = {rem_q, dvd_q[VMAG_W-1]};
	assign rem   = rem_q;
	assign done  = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(VMAG_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			// The partial remainder stays below the divisor, so eight bits hold it.
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= 8'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[7:0];
			end
			dvd_q <= {dvd_q[VMAG_W-2:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sierra_dither_avg_filter_quantize.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sierra_dither_avg_filter_quantize
// Sierra error-diffusion quantizer around the average predictor, RGBA pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_* valid/ready channel; image_start
// marks the first pixel of an image. One adjusted pixel leaves on the out_*
// channel for every pixel that enters. The two registers, quant_step and
// image_width, sit on the APB port at byte addresses 0 and 4.
// A word passes from acceptance to out_valid through the ten error taps,
// read one at a time from the single read port of the error memory, a
// drain and a setup state, the bit-serial remainder unit, and the
// write-back of the memories. One pixel is in work at a time, and the
// sequencer returns to its idle state before it takes the next.
// The result waits in an output register; the next word is
// accepted while it waits, and only the write-back stalls when the receiver
// holds out_ready low with a result still pending.
// Reset clears the position, the left pixel and the registers. The pixel
// and error memories are not cleared; rows that were never written are
// never read, since reads are gated by the rows finished in the image.
// ----------------------------------------------------------------------------
module sierra_dither_avg_filter_quantize
	import sdaq_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        image_start,
	input  wire logic [7:0]  in_red,
	input  wire logic [7:0]  in_green,
	input  wire logic [7:0]  in_blue,
	input  wire logic [7:0]  in_alpha,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  out_red,
	output logic      [7:0]  out_green,
	output logic      [7:0]  out_blue,
	output logic      [7:0]  out_alpha
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int AW = $clog2(3 * MAX_WIDTH);
	localparam int EM_W = NUM_CH * ERR_W;
	localparam int PM_W = NUM_CH * PIX_W;

	cfg_t cfg;

	sdaq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Memories: errors of three rows, emitted pixels of the row above.
	logic [EM_W-1:0] err_mem [3*MAX_WIDTH];
	logic [PM_W-1:0] pix_mem [MAX_WIDTH];
	logic [EM_W-1:0] err_rd_s1;
	logic [PM_W-1:0] pix_rd_s1;
	logic [AW-1:0]   err_raddr;
	logic [AW-1:0]   err_waddr;
	logic [EM_W-1:0] err_wdata;
	logic [PM_W-1:0] pix_wdata;
	logic            mem_we;

	state_t state_q, state_d;

	logic [CW-1:0]   col_q;
	logic [1:0]      rows_q;
	logic [1:0]      phase_q;
	logic [PIX_W-1:0] left_q [NUM_CH];

	logic [CW-1:0]   x_q;
	logic [CW-1:0]   w_q;
	logic [7:0]      qs_q;
	logic [1:0]      cur_q, up1_q, up2_q;
	logic            has_up1_q, has_up2_q;
	logic [PIX_W-1:0] here_q [NUM_CH];

	logic [TAP_W-1:0] tap_k_q;
	logic            tap_vld_s1;
	logic [2:0]      tap_wt_s1;
	logic            first_s1;
	logic signed [ACC_W-1:0] acc_q [NUM_CH];
	logic [PIX_W-1:0] up_q [NUM_CH];

	logic            vneg_s1 [NUM_CH];
	logic [VMAG_W-1:0] vabs_s1 [NUM_CH];
	logic [PIX_W-1:0] p_s1 [NUM_CH];
	logic            pass_s1 [NUM_CH];

	logic [7:0]      div_rem [NUM_CH];
	logic            div_done [NUM_CH];
	logic [VMAG_W-1:0] div_dvd [NUM_CH];
	logic            div_start;
	logic            all_done;

	logic            out_valid_q;
	logic [PIX_W-1:0] out_q [NUM_CH];
	logic [PIX_W-1:0] res_pix [NUM_CH];
	logic [ERR_W-1:0] res_err [NUM_CH];
	logic            fin_go;
	logic            accept;

	// Position bookkeeping at acceptance.
	logic [CW-1:0]   w_eff;
	logic [7:0]      q_eff;
	logic [CW-1:0]   col0, col1, coln, col_next;
	logic [1:0]      rows0, rows1, rows_next;
	logic [1:0]      ph0, ph1, ph_next;
	logic [PIX_W-1:0] in_pix [NUM_CH];

	assign in_pix[0] = in_red;
	assign in_pix[1] = in_green;
	assign in_pix[2] = in_blue;
	assign in_pix[3] = in_alpha;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (cfg.image_width == 12'd0) begin
			w_eff = CW'(1);
		end else if ({20'd0, cfg.image_width} > 32'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(cfg.image_width);
		end
		q_eff = (cfg.quant_step == 8'd0) ? 8'd1 : cfg.quant_step;

		col0  = image_start ? '0 : col_q;
		rows0 = image_start ? 2'd0 : rows_q;
		ph0   = image_start ? 2'd0 : phase_q;
		if (col0 >= w_eff) begin
			col1  = '0;
			rows1 = (rows0 == 2'd3) ? rows0 : rows0 + 2'd1;
			ph1   = phase_add(ph0, 2'd1);
		end else begin
			col1  = col0;
			rows1 = rows0;
			ph1   = ph0;
		end
		coln = col1 + 1'b1;
		if (coln >= w_eff) begin
			col_next  = '0;
			rows_next = (rows1 == 2'd3) ? rows1 : rows1 + 2'd1;
			ph_next   = phase_add(ph1, 2'd1);
		end else begin
			col_next  = coln;
			rows_next = rows1;
			ph_next   = ph1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			rows_q  <= 2'd0;
			phase_q <= 2'd0;
		end else if (accept) begin
			col_q   <= col_next;
			rows_q  <= rows_next;
			phase_q <= ph_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q       <= col1;
			w_q       <= w_eff;
			qs_q      <= q_eff;
			cur_q     <= ph1;
			up1_q     <= phase_add(ph1, 2'd2);
			up2_q     <= phase_add(ph1, 2'd1);
			has_up1_q <= (rows1 >= 2'd1);
			has_up2_q <= (rows1 >= 2'd2);
			for (int c = 0; c < NUM_CH; c++) begin
				here_q[c] <= in_pix[c];
			end
		end
	end

	// Tap address and gate for the tap being issued.
	logic [1:0]        t_row;
	logic [1:0]        t_slot;
	logic              t_row_ok;
	logic signed [CW+1:0] t_col;
	logic              t_gate;

	always_comb begin
		t_row = tap_row(tap_k_q);
		case (t_row)
			ROW_UP1: begin
				t_slot   = up1_q;
				t_row_ok = has_up1_q;
			end
			ROW_UP2: begin
				t_slot   = up2_q;
				t_row_ok = has_up2_q;
			end
			default: begin
				t_slot   = cur_q;
				t_row_ok = 1'b1;
			end
		endcase
		t_col  = $signed({2'b00, x_q}) + (CW+2)'(tap_dx(tap_k_q));
		t_gate = t_row_ok && (t_col >= 0) && (t_col < $signed({2'b00, w_q}));
		err_raddr = AW'(AW'(t_slot) * AW'(MAX_WIDTH) + AW'(t_col[XW-1:0]));
	end

	// Memory ports: one read and one write each, read data registered.
	always_ff @(posedge clk) begin
		err_rd_s1 <= err_mem[err_raddr];
		pix_rd_s1 <= pix_mem[x_q[XW-1:0]];
		if (mem_we) begin
			err_mem[err_waddr]       <= err_wdata;
			pix_mem[x_q[XW-1:0]]     <= pix_wdata;
		end
	end

	assign err_waddr = AW'(AW'(cur_q) * AW'(MAX_WIDTH) + AW'(x_q[XW-1:0]));
	assign mem_we    = (state_q == ST_FIN) && fin_go;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			err_wdata[c*ERR_W +: ERR_W] = res_err[c];
			pix_wdata[c*PIX_W +: PIX_W] = res_pix[c];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tap_k_q    <= '0;
			tap_vld_s1 <= 1'b0;
			first_s1   <= 1'b0;
		end else begin
			state_q    <= state_d;
			tap_vld_s1 <= (state_q == ST_TAP);
			first_s1   <= (state_q == ST_TAP) && (tap_k_q == '0);
			if (state_q == ST_TAP) begin
				tap_k_q <= tap_k_q + 1'b1;
			end else begin
				tap_k_q <= '0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_TAP;
			ST_TAP: begin
				if (tap_k_q == TAP_W'(NUM_TAPS - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_PREP;
			ST_PREP: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: if (all_done) state_d = ST_FIN;
			ST_FIN: if (fin_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Weighted tap accumulation, one tap per cycle.
	logic gate_s1;

	always_ff @(posedge clk) begin
		gate_s1   <= t_gate;
		tap_wt_s1 <= tap_wt(tap_k_q);
		if (tap_vld_s1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if (gate_s1) begin
					acc_q[c] <= (first_s1 ? ACC_W'(0) : acc_q[c])
						+ ACC_W'($signed({1'b0, tap_wt_s1})
						* $signed(err_rd_s1[c*ERR_W +: ERR_W]));
				end else if (first_s1) begin
					acc_q[c] <= '0;
				end
			end
		end
		if (first_s1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				up_q[c] <= pix_rd_s1[c*PIX_W +: PIX_W];
			end
		end
	end

	logic [ACC_W-1:0]    s_mag [NUM_CH];
	logic signed [V_W-1:0] d_val [NUM_CH];
	logic signed [V_W-1:0] v_val [NUM_CH];
	logic [PIX_W-1:0]    pred [NUM_CH];
	logic [PIX_W:0]      psum [NUM_CH];
	logic [V_W-1:0]      v_neg [NUM_CH];

	// Residual setup: diffusion term, predictor and half step.
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			for (int c = 0; c < NUM_CH; c++) begin
				vneg_s1[c] <= v_val[c][V_W-1];
				vabs_s1[c] <= div_dvd[c];
				p_s1[c]    <= pred[c];
				pass_s1[c] <= (here_q[c] == 8'd0) || (here_q[c] == 8'd255);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			// The sum divided by 32, rounded toward zero.
			s_mag[c] = acc_q[c][ACC_W-1] ? ACC_W'(-acc_q[c]) : ACC_W'(acc_q[c]);
			d_val[c] = acc_q[c][ACC_W-1] ? -$signed(V_W'(s_mag[c] >> 5))
				: $signed(V_W'(s_mag[c] >> 5));
			psum[c]  = (has_up1_q ? {1'b0, up_q[c]} : 9'd0)
				+ ((x_q != '0) ? {1'b0, left_q[c]} : 9'd0);
			pred[c]  = psum[c][PIX_W:1];
			v_val[c] = d_val[c] + $signed({4'd0, here_q[c]})
				- $signed({4'd0, pred[c]}) + $signed({5'd0, qs_q[7:1]});
			v_neg[c] = V_W'(-v_val[c]);
			div_dvd[c] = v_val[c][V_W-1] ? v_neg[c][VMAG_W-1:0] : v_val[c][VMAG_W-1:0];
		end
	end

	for (genvar g = 0; g < NUM_CH; g++) begin : g_div
		sdaq_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (div_dvd[g]),
			.divisor  (qs_q),
			.rem      (div_rem[g]),
			.done     (div_done[g])
		);
	end

	assign all_done = div_done[0] && div_done[1] && div_done[2] && div_done[3];

	// Final value: cut toward zero to a step multiple, add back the predictor.
	logic [VMAG_W-1:0]   m_mag [NUM_CH];
	logic signed [V_W-1:0] r_val [NUM_CH];
	logic signed [V_W-1:0] res_val [NUM_CH];
	logic                res_ok [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			m_mag[c]   = vabs_s1[c] - VMAG_W'(div_rem[c]);
			r_val[c]   = vneg_s1[c] ? -$signed({2'b00, m_mag[c]})
				: $signed({2'b00, m_mag[c]});
			res_val[c] = r_val[c] + $signed({4'd0, p_s1[c]});
			res_ok[c]  = !pass_s1[c] && (res_val[c] >= 0) && (res_val[c] <= 255);
			res_pix[c] = res_ok[c] ? res_val[c][PIX_W-1:0] : here_q[c];
			res_err[c] = res_ok[c] ? ERR_W'({1'b0, here_q[c]} - {1'b0, res_val[c][PIX_W-1:0]})
				: '0;
		end
	end

	assign fin_go = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CH; c++) begin
				left_q[c] <= '0;
			end
		end else begin
			if (mem_we) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			for (int c = 0; c < NUM_CH; c++) begin
				if (mem_we) begin
					left_q[c] <= res_pix[c];
				end else if (accept && image_start) begin
					left_q[c] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int c = 0; c < NUM_CH; c++) begin
				out_q[c] <= res_pix[c];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_q[0];
	assign out_green = out_q[1];
	assign out_blue  = out_q[2];
	assign out_alpha = out_q[3];

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAP) |-> (tap_k_q < TAP_W'(NUM_TAPS)))
		else $error("tap counter ran past the last tap");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("row phase left the range of three slots");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> out_valid_q)
		else $error("write-back did not raise the output word");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (x_q < w_q))
		else $error("column in work lies outside the row");

endmodule
`default_nettype wire
